// ===== rtl/raa_pkg.sv =====
// raa_pkg: shared types and constants for the rational adder
// used by raa_back; no dependencies
`timescale 1ns / 1ps
package raa_pkg;
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL, BK_SIGN, BK_GCD, BK_DIVN, BK_DIVD, BK_DONE
   } back_state_type;
endpackage

// ===== rtl/raa_front.sv =====
// raa_front: input stage, splits operands into sign and magnitude
// and flags zero denominators
`timescale 1ns / 1ps
module raa_front #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [WIDTH-1:0] req_a_num,
   input  logic [WIDTH-1:0] req_a_den,
   input  logic [WIDTH-1:0] req_b_num,
   input  logic [WIDTH-1:0] req_b_den,
   output logic             q_valid,
   input  logic             q_take,
   output logic [4*WIDTH-1:0] q_mag,
   output logic [3:0]       q_sign,
   output logic             q_zden
);
   logic               valid_ff, valid_in;
   logic [4*WIDTH-1:0] mag_ff, mag_in;
   logic [3:0]         sign_ff, sign_in;
   logic               zden_ff, zden_in;
   logic [WIDTH-1:0]   ops [4];

   assign req_full = valid_ff;
   assign ops[0] = req_a_num;
   assign ops[1] = req_a_den;
   assign ops[2] = req_b_num;
   assign ops[3] = req_b_den;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sign_in[i] = ops[i][WIDTH-1];
         mag_in[i*WIDTH +: WIDTH] = ops[i][WIDTH-1] ? (~ops[i] + 1'b1) : ops[i];
      end
      zden_in = (req_a_den == '0) || (req_b_den == '0);
      valid_in = valid_ff;
      if (q_take) valid_in = 1'b0;
      if (req_push && !valid_ff) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_push && !valid_ff) begin
         mag_ff  <= mag_in;
         sign_ff <= sign_in;
         zden_ff <= zden_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_mag   = mag_ff;
   assign q_sign  = sign_ff;
   assign q_zden  = zden_ff;
endmodule

// ===== rtl/raa_back.sv =====
// raa_back: sequencer for products, binary gcd and two restoring divides
// uses raa_pkg
`timescale 1ns / 1ps
module raa_back #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_take,
   input  logic [4*WIDTH-1:0] q_mag,
   input  logic [3:0]         q_sign,
   input  logic               q_zden,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [WIDTH-1:0]   rsp_sum_num,
   output logic [WIDTH-1:0]   rsp_sum_den,
   output logic [1:0]         rsp_status
);
   localparam int W2 = 2 * WIDTH + 1;
   localparam int KW = $clog2(W2 + 1);
   localparam int CW = $clog2(W2 + 1);

   raa_pkg::back_state_type state_ff, state_in;
   logic [WIDTH-1:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic [3:0]       sg_ff;
   logic [1:0]       mstep_ff;
   logic [W2-1:0]    p1_ff, p2_ff, den_ff, num_ff, u_ff, v_ff;
   logic [W2-1:0]    q_ff, r_ff, n_ff;
   logic [KW-1:0]    k_ff;
   logic [CW-1:0]    cnt_ff;
   logic             sn_ff, gph_ff;
   logic             out_valid_ff;
   logic [WIDTH-1:0] out_num_ff, out_den_ff;
   logic [1:0]       out_st_ff;
   logic [W2-1:0]    g_full, r_sh, mag_d;
   logic [2*WIDTH-1:0] prod;
   logic [WIDTH-1:0] mul_x, mul_y;
   logic             fit_n, fit_d;
   logic [W2-1:0]    lim;

   assign lim = W2'(1) << (WIDTH - 1);
   assign q_take = (state_ff == raa_pkg::BK_IDLE) && q_valid && !out_valid_ff;

   // single shared multiplier
   always_comb begin
      case (mstep_ff)
         2'd0:    begin mul_x = ma_ff; mul_y = md_ff; end
         2'd1:    begin mul_x = mc_ff; mul_y = mb_ff; end
         default: begin mul_x = mb_ff; mul_y = md_ff; end
      endcase
   end
   assign prod  = mul_x * mul_y;
   assign g_full = u_ff << k_ff;
   assign r_sh  = {r_ff[W2-2:0], n_ff[W2-1]};
   assign mag_d = den_ff;
   assign fit_n = (num_ff < lim) || (sn_ff && num_ff == lim);
   assign fit_d = (mag_d < lim) || (sg_ff[1] != sg_ff[3] && mag_d == lim);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         raa_pkg::BK_IDLE: if (q_take && !q_zden) state_in = raa_pkg::BK_MUL;
         raa_pkg::BK_MUL:  if (mstep_ff == 2'd2) state_in = raa_pkg::BK_SIGN;
         raa_pkg::BK_SIGN: state_in = raa_pkg::BK_GCD;
         raa_pkg::BK_GCD:  if (num_ff == '0 || (gph_ff && v_ff == '0))
                              state_in = (num_ff == '0) ? raa_pkg::BK_DONE
                                                        : raa_pkg::BK_DIVN;
         raa_pkg::BK_DIVN: if (cnt_ff == CW'(W2)) state_in = raa_pkg::BK_DIVD;
         raa_pkg::BK_DIVD: if (cnt_ff == CW'(W2)) state_in = raa_pkg::BK_DONE;
         raa_pkg::BK_DONE: state_in = raa_pkg::BK_IDLE;
         default:          state_in = raa_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= raa_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         if (q_take && q_zden) begin
            out_valid_ff <= 1'b1;
            out_num_ff   <= '0;
            out_den_ff   <= '0;
            out_st_ff    <= raa_pkg::ST_ZERO_DEN;
         end
         if (state_ff == raa_pkg::BK_DONE) begin
            out_valid_ff <= 1'b1;
            if (num_ff == '0) begin
               out_num_ff <= '0;
               out_den_ff <= (sg_ff[1] != sg_ff[3]) ? '1 : WIDTH'(1);
               out_st_ff  <= raa_pkg::ST_OK;
            end else if (!fit_n || !fit_d) begin
               out_num_ff <= '0;
               out_den_ff <= '0;
               out_st_ff  <= raa_pkg::ST_OVERFLOW;
            end else begin
               out_num_ff <= sn_ff ? WIDTH'(~num_ff + 1'b1) : num_ff[WIDTH-1:0];
               out_den_ff <= (sg_ff[1] != sg_ff[3]) ? WIDTH'(~mag_d + 1'b1)
                                                    : mag_d[WIDTH-1:0];
               out_st_ff  <= raa_pkg::ST_OK;
            end
         end
      end
      case (state_ff)
         raa_pkg::BK_IDLE: begin
            ma_ff <= q_mag[0 +: WIDTH];
            mb_ff <= q_mag[WIDTH +: WIDTH];
            mc_ff <= q_mag[2*WIDTH +: WIDTH];
            md_ff <= q_mag[3*WIDTH +: WIDTH];
            sg_ff <= q_sign;
            mstep_ff <= 2'd0;
         end
         raa_pkg::BK_MUL: begin
            mstep_ff <= mstep_ff + 2'd1;
            case (mstep_ff)
               2'd0:    p1_ff  <= W2'(prod);
               2'd1:    p2_ff  <= W2'(prod);
               default: den_ff <= W2'(prod);
            endcase
         end
         raa_pkg::BK_SIGN: begin
            // combine products by sign
            if ((sg_ff[0] != sg_ff[3]) == (sg_ff[2] != sg_ff[1])) begin
               num_ff <= p1_ff + p2_ff;
               sn_ff  <= sg_ff[0] != sg_ff[3];
            end else if (p1_ff >= p2_ff) begin
               num_ff <= p1_ff - p2_ff;
               sn_ff  <= sg_ff[0] != sg_ff[3];
            end else begin
               num_ff <= p2_ff - p1_ff;
               sn_ff  <= sg_ff[2] != sg_ff[1];
            end
            u_ff   <= '0;
            v_ff   <= '0;
            k_ff   <= '0;
            gph_ff <= 1'b0;
            cnt_ff <= '0;
         end
         raa_pkg::BK_GCD: begin
            if (cnt_ff == '0) begin
               u_ff   <= num_ff;
               v_ff   <= den_ff;
               cnt_ff <= CW'(1);
            end else if (!gph_ff) begin
               // strip common twos, then twos of u
               if (u_ff[0] == 1'b0 && v_ff[0] == 1'b0) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else if (u_ff[0] == 1'b0) begin
                  u_ff <= u_ff >> 1;
               end else begin
                  gph_ff <= 1'b1;
               end
            end else if (v_ff != '0) begin
               if (v_ff[0] == 1'b0) v_ff <= v_ff >> 1;
               else if (u_ff > v_ff) begin
                  u_ff <= v_ff;
                  v_ff <= u_ff - v_ff;
               end else v_ff <= v_ff - u_ff;
            end else begin
               u_ff   <= g_full;
               n_ff   <= num_ff;
               q_ff   <= '0;
               r_ff   <= '0;
               cnt_ff <= '0;
            end
         end
         raa_pkg::BK_DIVN, raa_pkg::BK_DIVD: begin
            if (cnt_ff == CW'(W2)) begin
               if (state_ff == raa_pkg::BK_DIVN) num_ff <= q_ff;
               else den_ff <= q_ff;
               n_ff   <= den_ff;
               q_ff   <= '0;
               r_ff   <= '0;
               cnt_ff <= '0;
            end else begin
               n_ff   <= n_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (r_sh >= u_ff) begin
                  r_ff <= r_sh - u_ff;
                  q_ff <= {q_ff[W2-2:0], 1'b1};
               end else begin
                  r_ff <= r_sh;
                  q_ff <= {q_ff[W2-2:0], 1'b0};
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_sum_num = out_num_ff;
   assign rsp_sum_den = out_den_ff;
   assign rsp_status  = out_st_ff;
endmodule

// ===== rtl/rational_add_reduce.sv =====
// rational_add_reduce: top level of the reduced fraction adder
// instantiates raa_front and raa_back
`timescale 1ns / 1ps
// adds req_a_num/req_a_den and req_b_num/req_b_den exactly and returns the
// sum reduced by its positive gcd, with the denominator carrying the sign of
// the product of the input denominators; a zero input denominator returns
// status 1 and a reduced part that does not fit WIDTH signed bits returns
// status 2, both with zero fields. a front stage holds one classified item
// so a new item can be pushed while the back works. the back runs on one
// shared multiplier, a binary gcd with one shift or subtract a cycle, then
// two restoring divides; a zero sum skips the gcd and the divides, and a
// zero denominator is answered without running the sequence
module rational_add_reduce #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [WIDTH-1:0] req_a_num,
   input  logic [WIDTH-1:0] req_a_den,
   input  logic [WIDTH-1:0] req_b_num,
   input  logic [WIDTH-1:0] req_b_den,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [WIDTH-1:0] rsp_sum_num,
   output logic [WIDTH-1:0] rsp_sum_den,
   output logic [1:0]       rsp_status
);
   // front-to-back item queue
   logic               q_valid, q_take, q_zden;
   logic [4*WIDTH-1:0] q_mag;
   logic [3:0]         q_sign;

   raa_front #(.WIDTH(WIDTH)) u_front (
      .clock, .reset, .req_push, .req_full,
      .req_a_num, .req_a_den, .req_b_num, .req_b_den,
      .q_valid, .q_take, .q_mag, .q_sign, .q_zden
   );

   raa_back #(.WIDTH(WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_mag, .q_sign, .q_zden,
      .rsp_empty, .rsp_pop, .rsp_sum_num, .rsp_sum_den, .rsp_status
   );
endmodule
